### src/arm64pr_pkg.sv
// shared types and constants for the arm64 pc-relative relocator
package arm64pr_pkg;

  localparam int InsnW = 32;
  localparam int AddrW = 64;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_B26,
    CLS_W19,
    CLS_W14,
    CLS_ADR,
    CLS_ADRP
  } insn_class_t;

  localparam logic [31:0] MaskB     = 32'h7C00_0000;
  localparam logic [31:0] MatchB    = 32'h1400_0000;
  localparam logic [31:0] MaskBc    = 32'hFF00_0010;
  localparam logic [31:0] MatchBc   = 32'h5400_0000;
  localparam logic [31:0] MaskCb    = 32'h7E00_0000;
  localparam logic [31:0] MatchCb   = 32'h3400_0000;
  localparam logic [31:0] MatchTb   = 32'h3600_0000;
  localparam logic [31:0] MaskAdr   = 32'h1F00_0000;
  localparam logic [31:0] MatchAdr  = 32'h1000_0000;
  localparam logic [31:0] MaskLdr   = 32'h3B00_0000;
  localparam logic [31:0] MatchLdr  = 32'h1800_0000;

  localparam logic [63:0] PageMask  = ~64'hFFF;

  function automatic insn_class_t classify(input logic [31:0] w);
    insn_class_t c;
    c = CLS_NONE;
    if ((w & MaskB) == MatchB) begin
      c = CLS_B26;
    end else if ((w & MaskBc) == MatchBc || (w & MaskCb) == MatchCb) begin
      c = CLS_W19;
    end else if ((w & MaskCb) == MatchTb) begin
      c = CLS_W14;
    end else if ((w & MaskAdr) == MatchAdr) begin
      c = w[31] ? CLS_ADRP : CLS_ADR;
    end else if ((w & MaskLdr) == MatchLdr) begin
      c = CLS_W19;
    end
    return c;
  endfunction

endpackage

### src/arm64_pc_relative_relocator.sv
// arm64 pc-relative instruction relocator, four stage pipeline
//
// input channel: insn_word, src_addr and dst_addr with in_valid / in_stall.
// a word is taken at a rising edge with in_valid high and in_stall low.
// output channel: new_insn and ok with out_valid / out_stall, one result
// word for every input word, in order.
// stage 1 decodes the class, sign-extends the offset and forms src - dst,
// stage 2 adds the old offset to get the new byte offset, stage 3 takes
// its magnitude, stage 4 scales it, checks the field range and re-encodes.
// one word can enter every cycle while in_stall is low.
// when out_stall is high and out_valid is set the last stage holds; earlier stages keep moving
// into empty slots, so bubbles close up and nothing is lost or repeated.
// in_stall rises only when the whole pipe is full and the output is held.
// rst (synchronous) empties the pipe; data registers keep their contents.
// words that match no pc-relative class pass unchanged with ok high; an
// out of range offset gives the original word with ok low.
module arm64_pc_relative_relocator
  import arm64pr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [InsnW-1:0] insn_word,
  input  logic [AddrW-1:0] src_addr,
  input  logic [AddrW-1:0] dst_addr,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [InsnW-1:0] new_insn,
  output logic             ok
);

  // stage 1
  logic             v1;
  logic [InsnW-1:0] insn1;
  insn_class_t      cls1;
  logic [AddrW-1:0] base1;
  logic [AddrW-1:0] off1;
  // stage 2
  logic             v2;
  logic [InsnW-1:0] insn2;
  insn_class_t      cls2;
  logic [AddrW-1:0] diff2;
  // stage 3
  logic             v3;
  logic [InsnW-1:0] insn3;
  insn_class_t      cls3;
  logic             neg3;
  logic [AddrW-1:0] mag3;

  logic en1, en2, en3, en4;

  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  // stage 1 logic
  insn_class_t      cls_in;
  logic [AddrW-1:0] off_in;
  logic [AddrW-1:0] base_in;
  logic [20:0]      imm21;

  always_comb begin
    cls_in  = classify(insn_word);
    imm21   = {insn_word[23:5], insn_word[30:29]};
    off_in  = '0;
    base_in = src_addr - dst_addr;
    unique case (cls_in)
      CLS_B26:  off_in = {{36{insn_word[25]}}, insn_word[25:0], 2'b00};
      CLS_W19:  off_in = {{43{insn_word[23]}}, insn_word[23:5], 2'b00};
      CLS_W14:  off_in = {{48{insn_word[18]}}, insn_word[18:5], 2'b00};
      CLS_ADR:  off_in = {{43{imm21[20]}}, imm21};
      CLS_ADRP: begin
        off_in  = {{31{imm21[20]}}, imm21, 12'h000};
        base_in = (src_addr & PageMask) - (dst_addr & PageMask);
      end
      CLS_NONE: off_in = '0;
      default:  off_in = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      insn1 <= insn_word;
      cls1  <= cls_in;
      base1 <= base_in;
      off1  <= off_in;
    end
  end

  // stage 2: new byte offset
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      insn2 <= insn1;
      cls2  <= cls1;
      diff2 <= base1 + off1;
    end
  end

  // stage 3: magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      insn3 <= insn2;
      cls3  <= cls2;
      neg3  <= diff2[AddrW-1];
      mag3  <= diff2[AddrW-1] ? (AddrW'(0) - diff2) : diff2;
    end
  end

  // stage 4: scale, range check, re-encode
  logic [AddrW-1:0] mag_sh;
  logic [AddrW-1:0] lim;
  logic [25:0]      fld;
  logic             fits;
  logic [InsnW-1:0] enc;

  always_comb begin
    mag_sh = mag3 >> 2;
    lim    = 64'd1 << 25;
    unique case (cls3)
      CLS_B26:  lim = 64'd1 << 25;
      CLS_W19:  lim = 64'd1 << 18;
      CLS_W14:  lim = 64'd1 << 13;
      CLS_ADR: begin
        mag_sh = mag3;
        lim    = 64'd1 << 20;
      end
      CLS_ADRP: begin
        mag_sh = mag3 >> 12;
        lim    = 64'd1 << 20;
      end
      CLS_NONE: lim = 64'd1 << 25;
      default:  lim = 64'd1 << 25;
    endcase
    fits = neg3 ? (mag_sh <= lim) : (mag_sh < lim);
    fld  = neg3 ? (26'd0 - mag_sh[25:0]) : mag_sh[25:0];
    enc  = insn3;
    unique case (cls3)
      CLS_B26:  enc = {insn3[31:26], fld[25:0]};
      CLS_W19:  enc = {insn3[31:24], fld[18:0], insn3[4:0]};
      CLS_W14:  enc = {insn3[31:19], fld[13:0], insn3[4:0]};
      CLS_ADR,
      CLS_ADRP: enc = {insn3[31], fld[1:0], insn3[28:24], fld[20:2], insn3[4:0]};
      CLS_NONE: enc = insn3;
      default:  enc = insn3;
    endcase
    if (cls3 == CLS_NONE) begin
      fits = 1'b1;
    end
    if (!fits) begin
      enc = insn3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
    if (en4) begin
      new_insn <= enc;
      ok       <= fits;
    end
  end

endmodule
